FILE: hdl/gbob_pkg.sv
// ---------------------------------------------------------------------------
// gbob_pkg
// Shared constants and codes for the glyph border outline blitter.
// ---------------------------------------------------------------------------
`default_nettype none

package gbob_pkg;

    // Default frame store geometry and border limit
    localparam int unsigned FRAME_COLS_DEF = 256;
    localparam int unsigned FRAME_ROWS_DEF = 256;
    localparam int unsigned MAX_BORDER_DEF = 8;

    // Signed coordinate width: 10-bit origin plus 8-bit glyph offset plus
    // border on both sides stays well inside 12 bits
    localparam int unsigned CW = 12;
    // Clamped radius width, holds up to 16
    localparam int unsigned RW = 5;
    // Signed diamond offset width, holds -16..16
    localparam int unsigned OW = 6;

    // Byte saturation limit
    localparam logic [7:0] PIX_MAX = 8'hFF;

    // Register reset values
    localparam logic [3:0] BORDER_RST  = 4'd1;
    localparam logic       OUTLINE_RST = 1'b1;
    localparam logic [8:0] WIDTH_RST   = 9'd256;
    localparam logic [8:0] HEIGHT_RST  = 9'd256;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_STAMP = 2'd1,
        MODE_BLEND = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BORDER  = 2'd0,
        REG_OUTLINE = 2'd1,
        REG_WIDTH   = 2'd2,
        REG_HEIGHT  = 2'd3
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: hdl/glyph_border_outline_blit.sv
// ---------------------------------------------------------------------------
// glyph_border_outline_blit
// RGBA frame store with pixel write/read, diamond border stamp and white
// glyph blend, driven by a stream of requests.
// ---------------------------------------------------------------------------
// One request is handled at a time; every request gives exactly one result
// transfer. A clipped request touches no pixel. A write or a read is a single
// store access; a blend reads the pixel, multiplies, divides and writes it
// back, but only while the outline register is set, and else leaves it as
// it is. A border stamp of radius r walks the 2r*r + 2r + 1 diamond points
// and reads then writes each point inside the frame on the single frame
// store port. The next request is taken as soon as the result sits in the
// output register, even if the sink has not yet taken it. The frame store has
// no reset and no clearing pass: pixels must be written before they are read,
// stamped or blended. Pixel (x, y) lies at address {y, x}.
`default_nettype none

module glyph_border_outline_blit
    import gbob_pkg::*;
#(
    parameter int unsigned FRAME_COLS = FRAME_COLS_DEF,
    parameter int unsigned FRAME_ROWS = FRAME_ROWS_DEF,
    parameter int unsigned MAX_BORDER = MAX_BORDER_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,

    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Request stream
    input  wire         s_tvalid,
    output logic        s_tready,
    // [9:0] pos_x, [19:10] pos_y, [27:20] glyph_x, [35:28] glyph_y,
    // [43:36] coverage, [75:44] pixel_data, [79:76] zero
    input  wire  [79:0] s_tdata,
    // [1:0] mode
    input  wire  [1:0]  s_tuser,

    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // [31:0] read_data
    output logic [31:0] m_tdata,
    // [0] clipped
    output logic        m_tuser
);

    localparam int unsigned XW = $clog2(FRAME_COLS);
    localparam int unsigned YW = $clog2(FRAME_ROWS);
    localparam int unsigned AW = XW + YW;
    localparam int unsigned DEPTH = 2 ** AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD_WAIT,
        S_PT_RD,
        S_PT_WR,
        S_BL_MUL,
        S_BL_WR,
        S_DONE
    } state_t;

    // -----------------------------------------------------------------------
    // Helpers
    // -----------------------------------------------------------------------
    function automatic logic is_inside(input logic signed [CW-1:0] x,
                                       input logic signed [CW-1:0] y,
                                       input logic [8:0] w,
                                       input logic [8:0] h);
        logic in_x;
        logic in_y;
        in_x = !x[CW-1] && (x[CW-2:0] < (CW-1)'(w));
        in_y = !y[CW-1] && (y[CW-2:0] < (CW-1)'(h));
        return in_x && in_y;
    endfunction

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[8] ? PIX_MAX : sum[7:0];
    endfunction

    // Exact floor(v / 255) for v up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        logic [16:0] u;
        t = {1'b0, v} + 17'd1;
        u = t + (t >> 8);
        return u[15:8];
    endfunction

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [3:0] border_reg;
    logic       outline_reg;
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            border_reg  <= BORDER_RST;
            outline_reg <= OUTLINE_RST;
            width_reg   <= WIDTH_RST;
            height_reg  <= HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_BORDER:  border_reg  <= pwdata[3:0];
                REG_OUTLINE: outline_reg <= pwdata[0];
                REG_WIDTH:   width_reg   <= pwdata[8:0];
                REG_HEIGHT:  height_reg  <= pwdata[8:0];
                default:     ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_BORDER:  prdata = {28'd0, border_reg};
            REG_OUTLINE: prdata = {31'd0, outline_reg};
            REG_WIDTH:   prdata = {23'd0, width_reg};
            REG_HEIGHT:  prdata = {23'd0, height_reg};
            default:     prdata = '0;
        endcase
    end

    // Effective frame size and clamped radius
    logic [8:0]           fw_eff;
    logic [8:0]           fh_eff;
    logic [RW-1:0]        radius;
    logic signed [OW-1:0] radius_s;

    assign fw_eff = ({4'd0, width_reg} > 13'(FRAME_COLS)) ? 9'(FRAME_COLS) : width_reg;
    assign fh_eff = ({4'd0, height_reg} > 13'(FRAME_ROWS)) ? 9'(FRAME_ROWS) : height_reg;
    assign radius = ({1'b0, border_reg} > RW'(MAX_BORDER)) ? RW'(MAX_BORDER)
                                                           : {1'b0, border_reg};
    assign radius_s = $signed({1'b0, radius});

    // -----------------------------------------------------------------------
    // Frame store: one port, read data registered
    // -----------------------------------------------------------------------
    logic [31:0]   mem [DEPTH];
    logic [31:0]   mem_rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer registers
    // -----------------------------------------------------------------------
    state_t               state_reg,    state_next;
    mode_t                mode_reg,     mode_next;
    logic signed [9:0]    pos_x_reg,    pos_x_next;
    logic signed [9:0]    pos_y_reg,    pos_y_next;
    logic [7:0]           glyph_x_reg,  glyph_x_next;
    logic [7:0]           glyph_y_reg,  glyph_y_next;
    logic [7:0]           cov_reg,      cov_next;
    logic [31:0]          pix_reg,      pix_next;
    logic signed [CW-1:0] px_reg,       px_next;
    logic signed [CW-1:0] py_reg,       py_next;
    logic [AW-1:0]        addr_reg,     addr_next;
    logic                 ok_reg,       ok_next;
    logic signed [OW-1:0] by_reg,       by_next;
    logic signed [OW-1:0] bx_reg,       bx_next;
    logic signed [OW-1:0] span_reg,     span_next;
    logic [2:0][15:0]     prod_reg,     prod_next;
    logic [31:0]          res_data_reg, res_data_next;
    logic                 res_clip_reg, res_clip_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_data_reg, out_data_next;
    logic                 out_clip_reg, out_clip_next;

    // Addressed pixel: glyph pixel for stamp and blend, else the raw position
    logic signed [CW-1:0] tgt_x;
    logic signed [CW-1:0] tgt_y;
    logic                 tgt_in;
    logic [AW-1:0]        tgt_addr;

    always_comb
    begin
        tgt_x = {{(CW-10){pos_x_reg[9]}}, pos_x_reg};
        tgt_y = {{(CW-10){pos_y_reg[9]}}, pos_y_reg};
        if (mode_reg == MODE_STAMP || mode_reg == MODE_BLEND)
        begin
            tgt_x = tgt_x + $signed({{(CW-8){1'b0}}, glyph_x_reg})
                          + $signed({{(CW-RW){1'b0}}, radius});
            tgt_y = tgt_y + $signed({{(CW-8){1'b0}}, glyph_y_reg})
                          + $signed({{(CW-RW){1'b0}}, radius});
        end
    end

    assign tgt_in   = is_inside(tgt_x, tgt_y, fw_eff, fh_eff);
    assign tgt_addr = {YW'(tgt_y), XW'(tgt_x)};

    // Current diamond point
    logic signed [CW-1:0] pt_x;
    logic signed [CW-1:0] pt_y;
    logic                 pt_in;
    logic [AW-1:0]        pt_addr;

    assign pt_x    = px_reg + {{(CW-OW){bx_reg[OW-1]}}, bx_reg};
    assign pt_y    = py_reg + {{(CW-OW){by_reg[OW-1]}}, by_reg};
    assign pt_in   = is_inside(pt_x, pt_y, fw_eff, fh_eff);
    assign pt_addr = {YW'(pt_y), XW'(pt_x)};

    // Next row of the diamond
    logic signed [OW-1:0] by_inc;
    logic signed [OW-1:0] by_abs;
    logic signed [OW-1:0] span_inc;

    assign by_inc   = by_reg + OW'(1);
    assign by_abs   = by_inc[OW-1] ? -by_inc : by_inc;
    assign span_inc = radius_s - by_abs;

    // Blend arithmetic
    logic [7:0]       cov_inv;
    logic [15:0]      cov_x255;
    logic [2:0][7:0]  blend_byte;

    assign cov_inv  = PIX_MAX - cov_reg;
    assign cov_x255 = {cov_reg, 8'd0} - {8'd0, cov_reg};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            blend_byte[i] = div255(prod_reg[i] + cov_x255);
        end
    end

    // -----------------------------------------------------------------------
    // Next-state logic
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        glyph_x_next   = glyph_x_reg;
        glyph_y_next   = glyph_y_reg;
        cov_next       = cov_reg;
        pix_next       = pix_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        addr_next      = addr_reg;
        ok_next        = ok_reg;
        by_next        = by_reg;
        bx_next        = bx_reg;
        span_next      = span_reg;
        prod_next      = prod_reg;
        res_data_next  = res_data_reg;
        res_clip_next  = res_clip_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_clip_next  = out_clip_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = '0;

        // Output slot empties on a completed transfer
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next    = mode_t'(s_tuser);
                    pos_x_next   = $signed(s_tdata[9:0]);
                    pos_y_next   = $signed(s_tdata[19:10]);
                    glyph_x_next = s_tdata[27:20];
                    glyph_y_next = s_tdata[35:28];
                    cov_next     = s_tdata[43:36];
                    pix_next     = s_tdata[75:44];
                    state_next   = S_START;
                end
            end

            // Clip check and dispatch
            S_START:
            begin
                px_next       = tgt_x;
                py_next       = tgt_y;
                addr_next     = tgt_addr;
                res_clip_next = !tgt_in;
                res_data_next = '0;
                mem_addr      = tgt_addr;
                state_next    = S_DONE;
                if (tgt_in)
                begin
                    case (mode_reg)
                        MODE_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = pix_reg;
                        end
                        MODE_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                        MODE_STAMP:
                        begin
                            by_next    = -radius_s;
                            bx_next    = '0;
                            span_next  = '0;
                            state_next = S_PT_RD;
                        end
                        MODE_BLEND:
                        begin
                            if (outline_reg)
                            begin
                                mem_re     = 1'b1;
                                state_next = S_BL_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_RD_WAIT:
            begin
                res_data_next = mem_rdata_reg;
                state_next    = S_DONE;
            end

            // Fetch the next diamond point, skipped if off frame
            S_PT_RD:
            begin
                addr_next  = pt_addr;
                ok_next    = pt_in;
                mem_addr   = pt_addr;
                mem_re     = pt_in;
                state_next = S_PT_WR;
            end

            // Write back colour and saturated alpha, then step the diamond
            S_PT_WR:
            begin
                mem_we    = ok_reg;
                mem_wdata = {sat_add(mem_rdata_reg[31:24], cov_reg),
                             outline_reg ? 24'h000000 : 24'hFFFFFF};
                if (bx_reg == span_reg)
                begin
                    if (by_reg == radius_s)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        by_next    = by_inc;
                        span_next  = span_inc;
                        bx_next    = -span_inc;
                        state_next = S_PT_RD;
                    end
                end
                else
                begin
                    bx_next    = bx_reg + OW'(1);
                    state_next = S_PT_RD;
                end
            end

            // Colour bytes times inverse coverage
            S_BL_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_next[i] = 16'(mem_rdata_reg[8*i +: 8]) * 16'(cov_inv);
                end
                state_next = S_BL_WR;
            end

            S_BL_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {sat_add(mem_rdata_reg[31:24], cov_reg),
                              blend_byte[2], blend_byte[1], blend_byte[0]};
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_clip_next  = res_clip_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // -----------------------------------------------------------------------
    // State and output registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_WRITE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            glyph_x_reg   <= '0;
            glyph_y_reg   <= '0;
            cov_reg       <= '0;
            pix_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            addr_reg      <= '0;
            ok_reg        <= 1'b0;
            by_reg        <= '0;
            bx_reg        <= '0;
            span_reg      <= '0;
            prod_reg      <= '0;
            res_data_reg  <= '0;
            res_clip_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_clip_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            glyph_x_reg   <= glyph_x_next;
            glyph_y_reg   <= glyph_y_next;
            cov_reg       <= cov_next;
            pix_reg       <= pix_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            addr_reg      <= addr_next;
            ok_reg        <= ok_next;
            by_reg        <= by_next;
            bx_reg        <= bx_next;
            span_reg      <= span_next;
            prod_reg      <= prod_next;
            res_data_reg  <= res_data_next;
            res_clip_reg  <= res_clip_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_clip_reg  <= out_clip_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_clip_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
`ifndef SYNTH
    // Single-port store: never a read and a write in one cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("frame store read and write in the same cycle");

    // A clipped result never carries pixel data
    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_clip_reg) |-> (out_data_reg == 32'd0))
        else $error("clipped result with non-zero data");

    // Only one request in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in progress");
`endif

endmodule

`default_nettype wire
